// File: rtl/core/rscc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rscc_pkg: shared types and constants for the range set/clear/count bitset
// Opcodes, default sizing and the tree level sizing function.
// ---------------------------------------------------------------------------
package rscc_pkg;
   localparam int unsigned DefaultSize = 1024;
   localparam int unsigned MinLeaves   = 8;
   localparam int unsigned PosWidth    = 11;
   localparam int unsigned OpWidth     = 2;

   typedef enum logic [OpWidth-1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_COUNT = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // number of tree levels for a given size (leaves = 2**levels)
   function automatic int unsigned tree_levels(input int unsigned size);
      int unsigned lv;
      lv = 3;
      while ((32'd1 << lv) < size) lv = lv + 1;
      return lv;
   endfunction
endpackage

// File: rtl/core/rscc_walker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rscc_walker: bitset range set/clear/count over a bit memory
// Holds the bit vector in a synchronous memory of words and sweeps words of
// the clipped range one word per step, read-modify-write for set/clear, read only for count.
// ---------------------------------------------------------------------------
module rscc_walker #(
   parameter int unsigned SIZE = rscc_pkg::DefaultSize
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  rscc_pkg::op_type                 op,
   input  logic [rscc_pkg::PosWidth-1:0]    range_begin,
   input  logic [rscc_pkg::PosWidth-1:0]    range_end,
   output logic                             busy,
   output logic                             done,
   output logic                             done_count,
   output logic [rscc_pkg::PosWidth-1:0]    count
);
   import rscc_pkg::*;

   localparam int unsigned Levels = tree_levels(SIZE);
   localparam int unsigned Leaves = 1 << Levels;
   localparam int unsigned WordW  = 64;
   localparam int unsigned Words  = Leaves / WordW > 0 ? Leaves / WordW : 1;
   localparam int unsigned AW     = Words > 1 ? $clog2(Words) : 1;
   localparam int unsigned BW     = $clog2(WordW);
   localparam int unsigned CW     = $clog2(WordW + 1);

   typedef enum logic [2:0] {
      ST_WIPE, ST_IDLE, ST_READ, ST_MOD, ST_DONE
   } state_type;

   // bit memory
   logic [WordW-1:0] mem [Words];
   logic [WordW-1:0] rd_data_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [WordW-1:0] wr_data;
   logic [AW-1:0]    rd_addr;

   state_type                 state_ff, state_in;
   logic [AW:0]               addr_ff, addr_in;
   logic [PosWidth:0]         beg_ff, beg_in, end_ff, end_in;
   op_type                    op_ff, op_in;
   logic [PosWidth-1:0]       count_ff, count_in;
   logic [PosWidth:0]         end_clip;
   logic [WordW-1:0]          mask;
   logic [PosWidth+1:0]       word_lo;
   logic [CW-1:0]             pop;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_addr = addr_ff[AW-1:0];
   assign end_clip = ({1'b0, range_end} > (PosWidth+1)'(SIZE)) ?
                     (PosWidth+1)'(SIZE) : {1'b0, range_end};
   assign word_lo = (PosWidth+2)'(addr_ff) << BW;

   // mask of range bits in the current word
   always_comb begin
      for (int i = 0; i < WordW; i++) begin
         mask[i] = ((word_lo + (PosWidth+2)'(i)) >= {1'b0, beg_ff}) &&
                   ((word_lo + (PosWidth+2)'(i)) <  {1'b0, end_ff});
      end
   end

   always_comb begin
      pop = '0;
      for (int i = 0; i < WordW; i++) pop = pop + CW'(rd_data_ff[i] & mask[i]);
   end

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      beg_in   = beg_ff;
      end_in   = end_ff;
      op_in    = op_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_ff[AW-1:0];
      wr_data  = '0;
      unique case (state_ff)
         ST_WIPE: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == (AW+1)'(Words - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = op;
               beg_in   = {1'b0, range_begin};
               end_in   = end_clip;
               count_in = '0;
               addr_in  = (AW+1)'({1'b0, range_begin} >> BW);
               if (({1'b0, range_begin} >= end_clip) || op == OP_NONE) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_MOD;
         ST_MOD: begin
            case (op_ff)
               OP_SET: begin
                  wr_en = 1'b1; wr_data = rd_data_ff | mask;
               end
               OP_CLEAR: begin
                  wr_en = 1'b1; wr_data = rd_data_ff & ~mask;
               end
               default: count_in = count_ff + PosWidth'(pop);
            endcase
            addr_in = addr_ff + 1'b1;
            if (((PosWidth+2)'(addr_ff + 1'b1) << BW) >= {1'b0, end_ff}) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
      beg_ff   <= beg_in;
      end_ff   <= end_in;
      op_ff    <= op_in;
      count_ff <= count_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign done       = state_ff == ST_DONE;
   assign done_count = done && op_ff == OP_COUNT;
   assign count      = count_ff;

   // done is never raised while wiping
   a_no_start_wipe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WIPE |-> !done) else $error("done during wipe");
   // count never exceeds size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      done_count |-> count_ff <= PosWidth'(SIZE)) else $error("count too large");
   // modify always follows read
   a_read_mod: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_MOD) else $error("read without modify");
endmodule

// File: rtl/core/range_set_clear_count_bitset.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_set_clear_count_bitset: bit vector with range set, clear and count
// Accepts one item at a time and returns a count item for count requests.
// ---------------------------------------------------------------------------
// each word touched is read, then modified or counted; 64 bits per word. An empty
// range or unused opcode goes straight to the done state without a memory access.
// a new item is taken only when the walker is idle and no count result is pending
// reset: synchronous; after reset a wipe pass clears the memory
// while no item is accepted
module range_set_clear_count_bitset #(
   parameter int unsigned SIZE = rscc_pkg::DefaultSize
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // opcode[1:0], range_begin[12:2], range_end[23:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // ones_count[10:0], zeros above
);
   import rscc_pkg::*;

   logic                busy, done, done_count;
   logic [PosWidth-1:0] count;
   logic                rsp_valid_ff;
   logic [PosWidth-1:0] rsp_count_ff;
   logic                start;

   // accept only when idle and the result slot is free
   assign req_tready = !busy && !rsp_valid_ff;
   assign start      = req_tvalid && req_tready;

   rscc_walker #(.SIZE(SIZE)) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .op          (op_type'(req_tdata[1:0])),
      .range_begin (req_tdata[12:2]),
      .range_end   (req_tdata[23:13]),
      .busy        (busy),
      .done        (done),
      .done_count  (done_count),
      .count       (count)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_count) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done_count) rsp_count_ff <= count;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("accept while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(done_count)) else $error("stray result");
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the range set/clear/count bitset
// Drives set, clear, count and no-op items over the stream port, keeps a plain bit
// array as a shadow of the vector, and checks every count item against it or against a typed-in count.
// ---------------------------------------------------------------------------
module tb_top;
   import rscc_pkg::*;

   localparam int unsigned SIZE = DefaultSize;

   typedef struct {
      op_type            op;
      logic [10:0]       first;
      logic [10:0]       last;
      bit                known;
      logic [10:0]       count;
   } stim_row;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // opcode[1:0], range_begin[12:2], range_end[23:13]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // ones_count[10:0], zeros above

   bit          shadow_bits [SIZE];
   logic [10:0] count_queue [$];
   int          errors;
   bit          quiet_mode;
   stim_row     rows [$];

   range_set_clear_count_bitset #(.SIZE(SIZE)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // shadow update; pushes expected ones for count, pushes nothing otherwise
   function automatic void apply_range(op_type op, logic [10:0] first, logic [10:0] last);
      int unsigned e;
      int unsigned ones;
      e = (last > SIZE) ? SIZE : last;
      ones = 0;
      for (int unsigned i = first; i < e; i++) begin
         if (op == OP_SET) shadow_bits[i] = 1'b1;
         else if (op == OP_CLEAR) shadow_bits[i] = 1'b0;
         else if (op == OP_COUNT) ones += shadow_bits[i];
      end
      if (op == OP_COUNT) count_queue.push_back(ones[10:0]);
   endfunction

   // send one item, idling first now and then
   task automatic send_item(op_type op, logic [10:0] first, logic [10:0] last);
      while (!quiet_mode && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {last, first, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_range(op, first, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (count_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result side: random stall and check against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (count_queue.size() == 0) begin
               $display("%0t unexpected count item: expected none, actual %0d",
                        $time, rsp_tdata[10:0]);
               errors++;
            end else begin
               logic [10:0] want;
               want = count_queue.pop_front();
               if (rsp_tdata !== {5'd0, want}) begin
                  $display("%0t ones_count mismatch: expected %0d, actual %0d",
                           $time, want, rsp_tdata);
                  errors++;
               end
            end
         end
         rsp_tready <= quiet_mode || ($urandom_range(99) >= 7);
      end
   end

   function automatic stim_row mk(op_type op, int f, int l, bit k = 0, int c = 0);
      stim_row r;
      r.op = op; r.first = 11'(f); r.last = 11'(l); r.known = k; r.count = 11'(c);
      return r;
   endfunction

   initial begin
      op_type      op;
      logic [10:0] f;
      logic [10:0] l;
      int unsigned pick;
      errors     = 0;
      quiet_mode = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows; counts typed in where obvious
      rows.push_back(mk(OP_COUNT, 0, 1024, 1, 0));
      rows.push_back(mk(OP_SET, 0, 1024));
      rows.push_back(mk(OP_COUNT, 0, 1024, 1, 1024));
      rows.push_back(mk(OP_COUNT, 0, 2047, 1, 1024));
      rows.push_back(mk(OP_COUNT, 1023, 1024, 1, 1));
      rows.push_back(mk(OP_COUNT, 5, 5, 1, 0));
      rows.push_back(mk(OP_COUNT, 9, 3, 1, 0));
      rows.push_back(mk(OP_COUNT, 2047, 2047, 1, 0));
      rows.push_back(mk(OP_CLEAR, 100, 600));
      rows.push_back(mk(OP_COUNT, 0, 1024));
      rows.push_back(mk(OP_NONE, 0, 1024));
      rows.push_back(mk(OP_COUNT, 50, 700));
      rows.push_back(mk(OP_CLEAR, 1024, 2047));
      rows.push_back(mk(OP_SET, 300, 300));
      rows.push_back(mk(OP_SET, 1000, 1500));
      rows.push_back(mk(OP_COUNT, 990, 1024));
      rows.push_back(mk(OP_CLEAR, 0, 2047));
      rows.push_back(mk(OP_COUNT, 0, 1024, 1, 0));
      rows.push_back(mk(OP_SET, 511, 513));
      rows.push_back(mk(OP_COUNT, 0, 1024, 1, 2));
      rows.push_back(mk(OP_SET, 1365, 682));
      rows.push_back(mk(OP_COUNT, 682, 1365));
      foreach (rows[i]) begin
         if (rows[i].known && rows[i].op == OP_COUNT) begin
            drain();
            count_queue.push_back(rows[i].count);
            req_tvalid <= 1'b1;
            req_tdata  <= {rows[i].last, rows[i].first, rows[i].op};
            @(posedge clock);
            while (!req_tready) @(posedge clock);
         end else begin
            send_item(rows[i].op, rows[i].first, rows[i].last);
         end
      end

      // random part; a quiet stretch in the middle, a full pause once
      for (int n = 0; n < 1550; n++) begin
         quiet_mode = (n >= 600 && n < 800);
         if (n == 1000) drain();
         pick = $urandom_range(99);
         op = (pick < 35) ? OP_SET : (pick < 65) ? OP_CLEAR : (pick < 97) ? OP_COUNT : OP_NONE;
         if ($urandom_range(9) == 0) begin
            f = 11'($urandom_range(2047));
            l = 11'($urandom_range(2047));
         end else begin
            f = 11'($urandom_range(1023));
            l = 11'(f + $urandom_range(1024 - f));
         end
         send_item(op, f, l);
      end
      quiet_mode = 0;
      drain();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
